FILE: sv/scm_pkg.sv
package scm_pkg;

	localparam int unsigned CAPACITY_DEF = 32;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_FULL     = 3'd1,
		ST_DELETED  = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} scm_status_t;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} scm_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_INS,
		S_DEL_FIND,
		S_DEL_SHIFT,
		S_DONE
	} scm_state_t;

	typedef struct packed {
		logic              func;
		logic signed [7:0] value;
	} scm_cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] held_after;
	} scm_res_t;

endpackage

FILE: sv/sorted_char_multiset.sv
// Bounded multiset of signed 8-bit characters kept in ascending order in a
// single-port-pair ram. An insert places the value ahead of the first entry
// that is not less than it (refused with status full when all CAPACITY
// entries are in use); a delete removes the first equal entry, or reports
// not found or empty. Every command gives exactly one result: a status and
// the entry count after the operation. One command is in work at a time and
// cmd_stall is high until it is done. The ram moves or compares one entry a
// cycle through its one read and one write port: an insert shifts every
// entry not less than the value up one place, a delete compares from the
// bottom and then closes the gap behind the removed entry, and a full or
// empty refusal moves no entry. A finished result waits in an output
// register, so the next command may be taken while it is still stalled.
module sorted_char_multiset import scm_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  scm_cmd_t cmd,
	output logic     res_valid,
	input  logic     res_stall,
	output scm_res_t res
);

	localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	scm_state_t        state_q, state_d;
	logic              func_q;
	logic signed [7:0] val_q;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	scm_status_t       status_q, status_d;
	logic              res_valid_q;
	scm_res_t          res_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;
	logic signed [7:0] rd_s;

	logic              ge, eq, idx_zero, past_end, del_more, res_free;

	scm_store #(
		.DEPTH  (CAPACITY),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_s     = $signed(rdata);
	assign ge       = (rd_s >= val_q);
	assign eq       = (rd_s == val_q);
	assign idx_zero = (idx_q == '0);
	assign past_end = (idx_q >= cnt_q);
	assign del_more = ((idx_q + CNT_ONE) < cnt_q);
	assign res_free = !res_valid_q || !res_stall;

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_START;
				end
			end
			S_START: begin
				if (func_q == OP_INSERT) begin
					state_d = (cnt_q >= CNT_FULL) ? S_DONE : S_INS;
				end else begin
					state_d = (cnt_q == '0) ? S_DONE : S_DEL_FIND;
				end
			end
			S_INS: begin
				if (idx_zero || !ge) begin
					state_d = S_DONE;
				end
			end
			S_DEL_FIND: begin
				if (past_end) begin
					state_d = S_DONE;
				end else if (eq) begin
					state_d = S_DEL_SHIFT;
				end
			end
			S_DEL_SHIFT: begin
				if (!del_more) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we       = 1'b0;
		waddr    = idx_q[ADDR_W-1:0];
		wdata    = rdata;
		raddr    = idx_q[ADDR_W-1:0];
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		status_d = status_q;
		unique case (state_q)
			S_IDLE: begin
			end
			S_START: begin
				if (func_q == OP_INSERT) begin
					if (cnt_q >= CNT_FULL) begin
						status_d = ST_FULL;
					end else begin
						// walk down from the top, first read is the last entry
						idx_d = cnt_q;
						raddr = ADDR_W'(cnt_q - CNT_ONE);
					end
				end else begin
					if (cnt_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						idx_d = '0;
						raddr = '0;
					end
				end
			end
			S_INS: begin
				we = 1'b1;
				if (!idx_zero && ge) begin
					// entry not less than value moves up one place
					wdata = rdata;
					idx_d = idx_q - CNT_ONE;
					raddr = ADDR_W'(idx_q - CNT_TWO);
				end else begin
					wdata    = val_q;
					cnt_d    = cnt_q + CNT_ONE;
					status_d = ST_INSERTED;
				end
			end
			S_DEL_FIND: begin
				raddr = ADDR_W'(idx_q + CNT_ONE);
				if (past_end) begin
					status_d = ST_NOTFOUND;
				end else if (!eq) begin
					idx_d = idx_q + CNT_ONE;
				end
			end
			S_DEL_SHIFT: begin
				if (del_more) begin
					// close the gap, read runs one entry ahead of the write
					we    = 1'b1;
					wdata = rdata;
					idx_d = idx_q + CNT_ONE;
					raddr = ADDR_W'(idx_q + CNT_TWO);
				end else begin
					cnt_d    = cnt_q - CNT_ONE;
					status_d = ST_DELETED;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			func_q <= cmd.func;
			val_q  <= cmd.value;
		end
		idx_q    <= idx_d;
		status_q <= status_d;
		if (state_q == S_DONE && res_free) begin
			res_q.status     <= status_q;
			res_q.held_after <= 6'(cnt_q);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("entry count above capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CNT_ONE) ||
			(cnt_q == $past(cnt_q) - CNT_ONE))
		else $error("entry count moved by more than one");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (state_q == S_START))
		else $error("command transfer did not start the sequencer");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_INS || state_q == S_DEL_SHIFT))
		else $error("ram write outside a shift step");

	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !$past(res_valid_q)) |-> $past(state_q == S_DONE))
		else $error("result raised without a finished command");

endmodule

FILE: sv/scm_store.sv
module scm_store import scm_pkg::*; #(
	parameter int unsigned DEPTH  = CAPACITY_DEF,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data registered, valid in the cycle after the address
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
